// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; the assertions drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assertion failed");
`define ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// File: sv/ucp_pkg.sv
// ----------------------------------------------------------------------------
// ucp_pkg
// Shared constants for the unit cross product pipeline.
// ----------------------------------------------------------------------------
package ucp_pkg;
  // Extra front stages ahead of the square root cells: products, cross terms, sum of squares.
  localparam int unsigned FRONT_STAGES = 3;
endpackage

// File: sv/ucp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ucp_sqrt_cell
// One restoring square root step: decides one result bit per cycle while en_i is high.
// ----------------------------------------------------------------------------
module ucp_sqrt_cell import ucp_pkg::*; #(
  parameter int unsigned RW  = 34,
  parameter int unsigned SW  = 68,
  parameter int unsigned CW  = 34,
  parameter int unsigned BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [SW-1:0]        rem_i,
  input  logic [RW-1:0]        root_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  input  logic signed [CW-1:0] cz_i,
  output logic [SW-1:0]        rem_o,
  output logic [RW-1:0]        root_o,
  output logic signed [CW-1:0] cx_o,
  output logic signed [CW-1:0] cy_o,
  output logic signed [CW-1:0] cz_o
);
  // trial = (2*root*2^BIT + 4^BIT) ; root holds bits above BIT
  logic [SW+1:0] trial;
  logic [SW+1:0] rem_q_d;
  logic          take;
  logic [SW-1:0] rem_q;
  logic [RW-1:0] root_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;

  always_comb begin
    trial   = ({{(SW+2-RW){1'b0}}, root_i} << (BIT + 1))
            | ({{(SW+1){1'b0}}, 1'b1} << (2 * BIT));
    take    = {2'b00, rem_i} >= trial;
    rem_q_d = take ? ({2'b00, rem_i} - trial) : {2'b00, rem_i};
  end

  // Hold the step while the chain is stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_q_d[SW-1:0];
      root_q <= take ? (root_i | (RW'(1) << BIT)) : root_i;
      cx_q   <= cx_i;
      cy_q   <= cy_i;
      cz_q   <= cz_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign cx_o   = cx_q;
  assign cy_o   = cy_q;
  assign cz_o   = cz_q;
endmodule

// File: sv/ucp_div_cell.sv
// ----------------------------------------------------------------------------
// ucp_div_cell
// One restoring division step on three numerators sharing one divisor.
// ----------------------------------------------------------------------------
module ucp_div_cell import ucp_pkg::*; #(
  parameter int unsigned RW  = 34,
  parameter int unsigned NW  = 48,
  parameter int unsigned QW  = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [RW-1:0]         len_i,
  input  logic [3*NW-1:0]       num_i,
  input  logic [3*(RW+1)-1:0]   rem_i,
  input  logic [3*QW-1:0]       quo_i,
  input  logic [2:0]            neg_i,
  input  logic                  zero_i,
  output logic [RW-1:0]         len_o,
  output logic [3*NW-1:0]       num_o,
  output logic [3*(RW+1)-1:0]   rem_o,
  output logic [3*QW-1:0]       quo_o,
  output logic [2:0]            neg_o,
  output logic                  zero_o
);
  logic [3*NW-1:0]     num_d;
  logic [3*(RW+1)-1:0] rem_d;
  logic [3*QW-1:0]     quo_d;
  logic [RW:0]         sh;
  logic                ge;

  always_comb begin
    num_d = num_i;
    rem_d = rem_i;
    quo_d = quo_i;
    for (int k = 0; k < 3; k++) begin
      // Bring down the next numerator bit, subtract when it fits.
      sh = {rem_i[k*(RW+1) +: RW], num_i[k*NW + NW - 1]};
      ge = sh >= {1'b0, len_i};
      num_d[k*NW +: NW]      = {num_i[k*NW +: NW-1], 1'b0};
      rem_d[k*(RW+1) +: RW+1] = ge ? (sh - {1'b0, len_i}) : sh;
      quo_d[k*QW +: QW]      = {quo_i[k*QW +: QW-1], ge};
    end
  end

  // Hold the step while the chain is stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_o  <= len_i;
      num_o  <= num_d;
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      neg_o  <= neg_i;
      zero_o <= zero_i;
    end
  end
endmodule

// File: sv/unit_cross_product_3d.sv
// ----------------------------------------------------------------------------
// unit_cross_product_3d
// Normalized cross product of two integer vectors, output in signed Q1.OUT_FRAC.
// ----------------------------------------------------------------------------
// Usage: present a_*/b_* with in_valid_i; a transaction is taken when
// in_valid_i is high and in_stall_o low. Results come on n_* with
// out_valid_o, taken when out_stall_i is low.
// Pipeline: 3 front stages (products, cross terms, sum of squares), then one
// square root cell per root bit (2*IN_WIDTH+1), then one divide cell per
// numerator bit (2*IN_WIDTH+OUT_FRAC), then the rounding/output register.
// Throughput: one transaction per cycle while out_stall_i does not hold the
// chain; each cell does one bit step.
// A stall of the receiver freezes the whole chain: in_stall_o follows
// out_stall_i while the output register holds a result, so nothing is lost.
// Zero cross product gives (0, 0, 1.0).
// Reset clears only the valid bits of the chain; payload is not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module unit_cross_product_3d import ucp_pkg::*; #(
  parameter int unsigned IN_WIDTH = 16,
  parameter int unsigned OUT_FRAC = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [IN_WIDTH-1:0] a_x_i,
  input  logic signed [IN_WIDTH-1:0] a_y_i,
  input  logic signed [IN_WIDTH-1:0] a_z_i,
  input  logic signed [IN_WIDTH-1:0] b_x_i,
  input  logic signed [IN_WIDTH-1:0] b_y_i,
  input  logic signed [IN_WIDTH-1:0] b_z_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_FRAC+1:0] n_x_o,
  output logic signed [OUT_FRAC+1:0] n_y_o,
  output logic signed [OUT_FRAC+1:0] n_z_o
);
  localparam int unsigned PW  = 2 * IN_WIDTH;          // product
  localparam int unsigned CW  = PW + 1;                // cross term
  localparam int unsigned MW  = PW;                    // |c| fits 2*IN_WIDTH bits
  localparam int unsigned SW  = 2 * MW + 2;            // sum of squares
  localparam int unsigned RW  = SW / 2;                // root width
  localparam int unsigned NW  = MW + OUT_FRAC;         // scaled numerator
  localparam int unsigned QW  = OUT_FRAC + 2;          // quotient bits kept
  localparam int unsigned NS  = RW;                    // sqrt cells
  localparam int unsigned ND  = NW;                    // div cells
  localparam int unsigned DEPTH = FRONT_STAGES + NS + ND + 1;

  // Global advance: move when the output slot is free or being emptied.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic [DEPTH-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[DEPTH-1];

  // Every stage register below advances only on adv; a stall freezes all.

  // Front stage 1: six products.
  logic signed [PW-1:0] p_q [6];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= a_y_i * b_z_i;
      p_q[1] <= b_y_i * a_z_i;
      p_q[2] <= a_z_i * b_x_i;
      p_q[3] <= b_z_i * a_x_i;
      p_q[4] <= a_x_i * b_y_i;
      p_q[5] <= b_x_i * a_y_i;
    end
  end

  // Front stage 2: cross terms.
  logic signed [CW-1:0] c_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0] <= CW'(p_q[0]) - CW'(p_q[1]);
      c_q[1] <= CW'(p_q[2]) - CW'(p_q[3]);
      c_q[2] <= CW'(p_q[4]) - CW'(p_q[5]);
    end
  end

  // Front stage 3: squares summed (each square fits MW x MW after abs).
  logic [MW-1:0] m [3];
  logic [SW-1:0] s_q;
  logic signed [CW-1:0] c3_q [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m[k] = c_q[k][CW-1] ? MW'(-c_q[k]) : MW'(c_q[k]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q <= SW'(m[0] * m[0]) + SW'(m[1] * m[1]) + SW'(m[2] * m[2]);
      c3_q <= c_q;
    end
  end

  // Square root chain.
  logic [SW-1:0]        s_rem [NS+1];
  logic [RW-1:0]        s_root [NS+1];
  logic signed [CW-1:0] s_cx [NS+1];
  logic signed [CW-1:0] s_cy [NS+1];
  logic signed [CW-1:0] s_cz [NS+1];
  logic [SW-1:0]        s_rem_o [NS];
  logic [RW-1:0]        s_root_o [NS];
  logic signed [CW-1:0] s_cx_o [NS];
  logic signed [CW-1:0] s_cy_o [NS];
  logic signed [CW-1:0] s_cz_o [NS];

  assign s_rem[0]  = s_q;
  assign s_root[0] = '0;
  assign s_cx[0]   = c3_q[0];
  assign s_cy[0]   = c3_q[1];
  assign s_cz[0]   = c3_q[2];

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    ucp_sqrt_cell #(.RW(RW), .SW(SW), .CW(CW), .BIT(NS - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (s_rem[g]),
      .root_i (s_root[g]),
      .cx_i   (s_cx[g]),
      .cy_i   (s_cy[g]),
      .cz_i   (s_cz[g]),
      .rem_o  (s_rem_o[g]),
      .root_o (s_root_o[g]),
      .cx_o   (s_cx_o[g]),
      .cy_o   (s_cy_o[g]),
      .cz_o   (s_cz_o[g])
    );
    assign s_rem[g+1]  = s_rem_o[g];
    assign s_root[g+1] = s_root_o[g];
    assign s_cx[g+1]   = s_cx_o[g];
    assign s_cy[g+1]   = s_cy_o[g];
    assign s_cz[g+1]   = s_cz_o[g];
  end

  // Divider chain: numerator |c| << OUT_FRAC, divisor len.
  logic [3*NW-1:0]     d_num [ND+1];
  logic [3*(RW+1)-1:0] d_rem [ND+1];
  logic [3*QW-1:0]     d_quo [ND+1];
  logic [RW-1:0]       d_len [ND+1];
  logic [2:0]          d_neg [ND+1];
  logic                d_zero [ND+1];
  logic [3*NW-1:0]     d_num_o [ND];
  logic [3*(RW+1)-1:0] d_rem_o [ND];
  logic [3*QW-1:0]     d_quo_o [ND];
  logic [RW-1:0]       d_len_o [ND];
  logic [2:0]          d_neg_o [ND];
  logic                d_zero_o [ND];

  logic [MW-1:0] mx, my, mz;
  assign mx = s_cx[NS][CW-1] ? MW'(-s_cx[NS]) : MW'(s_cx[NS]);
  assign my = s_cy[NS][CW-1] ? MW'(-s_cy[NS]) : MW'(s_cy[NS]);
  assign mz = s_cz[NS][CW-1] ? MW'(-s_cz[NS]) : MW'(s_cz[NS]);
  assign d_num[0]  = {{mz, OUT_FRAC'(0)}, {my, OUT_FRAC'(0)}, {mx, OUT_FRAC'(0)}};
  assign d_rem[0]  = '0;
  assign d_quo[0]  = '0;
  assign d_len[0]  = s_root[NS];
  assign d_neg[0]  = {s_cz[NS][CW-1], s_cy[NS][CW-1], s_cx[NS][CW-1]};
  assign d_zero[0] = (s_root[NS] == '0);

  for (genvar g = 0; g < ND; g++) begin : g_div
    ucp_div_cell #(.RW(RW), .NW(NW), .QW(QW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .len_i  (d_len[g]),
      .num_i  (d_num[g]),
      .rem_i  (d_rem[g]),
      .quo_i  (d_quo[g]),
      .neg_i  (d_neg[g]),
      .zero_i (d_zero[g]),
      .len_o  (d_len_o[g]),
      .num_o  (d_num_o[g]),
      .rem_o  (d_rem_o[g]),
      .quo_o  (d_quo_o[g]),
      .neg_o  (d_neg_o[g]),
      .zero_o (d_zero_o[g])
    );
    assign d_num[g+1]  = d_num_o[g];
    assign d_rem[g+1]  = d_rem_o[g];
    assign d_quo[g+1]  = d_quo_o[g];
    assign d_len[g+1]  = d_len_o[g];
    assign d_neg[g+1]  = d_neg_o[g];
    assign d_zero[g+1] = d_zero_o[g];
  end

  // Round, clamp, sign, degenerate case.
  logic [QW-1:0] one_q;
  assign one_q = QW'(1) << OUT_FRAC;
  logic signed [QW-1:0] n_d [3];
  logic [QW-1:0] nx_q, ny_q, nz_q;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [RW:0]   r;
      logic [QW:0]   q;
      r = d_rem[ND][k*(RW+1) +: RW+1];
      q = {1'b0, d_quo[ND][k*QW +: QW]};
      if ({r, 1'b0} >= {1'b0, d_len[ND]}) q = q + 1'b1;
      if (q > {1'b0, one_q}) q = {1'b0, one_q};
      n_d[k] = d_neg[ND][k] ? -QW'(q) : QW'(q);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= d_zero[ND] ? '0 : n_d[0];
      ny_q <= d_zero[ND] ? '0 : n_d[1];
      nz_q <= d_zero[ND] ? one_q : n_d[2];
    end
  end
  assign n_x_o = nx_q;
  assign n_y_o = ny_q;
  assign n_z_o = nz_q;

  `ASSERT_IMPL(a_stall_holds_out, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(n_z_o)))
  `ASSERT_IMPL(a_stall_link, clk_i, rst_ni, in_stall_o == (out_valid_o && out_stall_i))
  `ASSERT_IMPL(a_range, clk_i, rst_ni, out_valid_o |-> (n_z_o <= $signed(one_q) && n_z_o >= -$signed(one_q)))
endmodule
